[rtl/box_filter_3x3_mean_core_defines.svh]
// Assertion macros shared by the checker files of the box filter.
`ifndef BOX_FILTER_3X3_MEAN_CORE_DEFINES_SVH
`define BOX_FILTER_3X3_MEAN_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BF3_ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("box filter check failed");

// The consequent must hold in the cycle after the antecedent.
`define BF3_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("box filter check failed");

`endif

[rtl/bf3_pkg.sv]
// Package with the constants, register codes and request types of the box filter.
package bf3_pkg;

    localparam int PIX_W         = 8;
    localparam int ROW_W         = 16;
    localparam int COL_OUT_W     = 10;
    localparam int WCFG_W        = 11;
    localparam int SUM_W         = 12;
    localparam int RECIP_W       = 13;
    localparam int RECIP_SHIFT   = 16;
    localparam int MAX_WIDTH_DEF = 1024;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [WCFG_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [ROW_W-1:0]   HEIGHT_RESET = 16'd480;
    localparam logic [RECIP_W-1:0] RECIP_9      = 13'd7282;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 4'd0,
        REG_IMAGE_HEIGHT = 4'd1
    } bf3_reg_t;

    typedef struct packed {
        logic                 has_border;
        logic                 has_interior;
        logic [PIX_W-1:0]     px;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
        logic [SUM_W-1:0]     sum;
    } bf3_req_t;

    typedef struct packed {
        logic     valid;
        bf3_req_t req;
    } bf3_push_t;

    typedef struct packed {
        logic     valid;
        bf3_req_t req;
    } bf3_head_t;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel_out;
        logic [ROW_W-1:0]     out_row;
        logic [COL_OUT_W-1:0] out_col;
        logic                 last_of_run;
    } bf3_res_t;

endpackage

[rtl/bf3_if.sv]
// Stream and configuration interfaces of the box filter.
interface bf3_pixel_if
    import bf3_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink (input valid, input pixel_in, output ready);
endinterface

interface bf3_result_if
    import bf3_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [PIX_W-1:0]     pixel_out;
    logic [ROW_W-1:0]     out_row;
    logic [COL_OUT_W-1:0] out_col;
    logic                 last_of_run;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output last_of_run, input ready);
    modport sink (input valid, input pixel_out, input out_row, input out_col,
                  input last_of_run, output ready);
endinterface

interface bf3_cfg_if
    import bf3_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/bf3_front.sv]
// Front end: configuration, position tracking, classification, row stores and window sum.
module bf3_front
    import bf3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    bf3_pixel_if.sink         pixel,
    bf3_cfg_if.sink           cfg,
    input  logic [QCNT_W-1:0] queue_count,
    output bf3_push_t         push
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > WCFG_W) ? CW + 1 : WCFG_W;

    logic [WCFG_W-1:0] width_reg;
    logic [ROW_W-1:0]  height_reg;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;

    logic [PIX_W-1:0] older_mem [MAX_WIDTH];
    logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
    logic [PIX_W-1:0] top_rd_reg;
    logic [PIX_W-1:0] mid_rd_reg;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [CW-1:0]    s1_col_reg;
    logic             s1_border_reg;
    logic             s1_interior_reg;

    logic [PIX_W-1:0] win_reg [6];

    logic [EW-1:0]    w_ext, w_eff, c_ext, last_col;
    logic [ROW_W-1:0] h_eff, last_row;
    logic             border, interior, accept;
    logic [QCNT_W:0]  occupancy;
    logic [SUM_W-1:0] sum;

    always_comb
    begin
        w_ext = EW'(width_reg);
        if (w_ext < EW'(3))
        begin
            w_eff = EW'(3);
        end
        else if (w_ext > EW'(MAX_WIDTH))
        begin
            w_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end
        h_eff    = (height_reg < ROW_W'(3)) ? ROW_W'(3) : height_reg;
        last_col = w_eff - EW'(1);
        last_row = h_eff - ROW_W'(1);
        c_ext    = EW'(col_reg);

        border   = (row_reg == '0) || (col_reg == '0) || (row_reg >= last_row) ||
                   (c_ext >= last_col);
        interior = (row_reg >= ROW_W'(2)) && (c_ext >= EW'(2)) && (row_reg <= last_row) &&
                   (c_ext <= last_col);

        if (c_ext + EW'(1) >= w_eff)
        begin
            col_next = '0;
            row_next = ({1'b0, row_reg} + 17'd1 >= {1'b0, h_eff}) ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
            row_next = row_reg;
        end
    end

    assign occupancy   = (QCNT_W + 1)'(queue_count) + (QCNT_W + 1)'(s1_valid_reg);
    assign pixel.ready = occupancy < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept      = pixel.valid && pixel.ready;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg.data[WCFG_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg.data[ROW_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg       <= pixel.pixel_in;
            s1_row_reg      <= row_reg;
            s1_col_reg      <= col_reg;
            s1_border_reg   <= border;
            s1_interior_reg <= interior;
        end
    end

    // The item in the second stage writes a column that differs from the one the
    // next item reads, so the row stores need no bypass.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_rd_reg <= older_mem[col_reg];
            mid_rd_reg <= newer_mem[col_reg];
        end
        if (s1_valid_reg)
        begin
            older_mem[s1_col_reg] <= mid_rd_reg;
            newer_mem[s1_col_reg] <= s1_px_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_rd_reg;
            win_reg[4] <= mid_rd_reg;
            win_reg[5] <= s1_px_reg;
        end
    end

    always_comb
    begin
        sum = SUM_W'(top_rd_reg) + SUM_W'(mid_rd_reg) + SUM_W'(s1_px_reg);
        for (int i = 0; i < 6; i++)
        begin
            sum = sum + SUM_W'(win_reg[i]);
        end
    end

    always_comb
    begin
        push.valid            = s1_valid_reg && (s1_border_reg || s1_interior_reg);
        push.req.has_border   = s1_border_reg;
        push.req.has_interior = s1_interior_reg;
        push.req.px           = s1_px_reg;
        push.req.row          = s1_row_reg;
        push.req.col          = COL_OUT_W'(s1_col_reg);
        push.req.sum          = sum;
    end

endmodule

[rtl/bf3_queue.sv]
// Short request queue between the front end and the output stage.
module bf3_queue
    import bf3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  bf3_push_t         push,
    input  logic              pop,
    output bf3_head_t         head,
    output logic [QCNT_W-1:0] count
);

    bf3_req_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = count_reg != '0;
    assign head.req   = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entry_reg[wr_ptr_reg] <= push.req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push.valid && !do_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (!push.valid && do_pop)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

[rtl/bf3_back.sv]
// Output stage: splits each request into its results, divides the window sum by nine.
module bf3_back
    import bf3_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  bf3_head_t     head,
    output logic          pop,
    bf3_result_if.source  result
);

    bf3_res_t out_reg, out_next;
    logic     out_valid_reg;
    logic     phase_reg;
    logic     load, take_border;

    logic [SUM_W+RECIP_W-1:0] product;
    logic [PIX_W-1:0]         quotient;

    // Multiplying by the rounded-up reciprocal gives the exact floor for sums up to 9 * 255.
    assign product  = (SUM_W + RECIP_W)'(head.req.sum) * (SUM_W + RECIP_W)'(RECIP_9);
    assign quotient = product[RECIP_SHIFT +: PIX_W];

    assign load        = head.valid && (!out_valid_reg || result.ready);
    assign take_border = head.req.has_border && !phase_reg;
    assign pop         = load && !(take_border && head.req.has_interior);

    always_comb
    begin
        if (take_border)
        begin
            out_next.pixel_out   = head.req.px;
            out_next.out_row     = head.req.row;
            out_next.out_col     = head.req.col;
            out_next.last_of_run = !head.req.has_interior;
        end
        else
        begin
            out_next.pixel_out   = quotient;
            out_next.out_row     = head.req.row - ROW_W'(1);
            out_next.out_col     = head.req.col - COL_OUT_W'(1);
            out_next.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= take_border && head.req.has_interior;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.pixel_out   = out_reg.pixel_out;
    assign result.out_row     = out_reg.out_row;
    assign result.out_col     = out_reg.out_col;
    assign result.last_of_run = out_reg.last_of_run;

endmodule

[rtl/box_filter_3x3_mean_core.sv]
// Top level of the 3x3 mean filter over a raster-order pixel stream.
//
//   channel   direction   payload
//   pixel     in          pixel_in
//   result    out         pixel_out, out_row, out_col, last_of_run
//   cfg       in          index, data (image_width, image_height)
//
// One pixel is taken per cycle while pixel.ready is high; the result port moves one result per
// cycle while result.ready is high; a pixel's border and interior results leave in turn.
// A pixel passes the row store read, the window sum into the queue and the output register.
// The row stores have no clearing pass; reset clears positions, window and control flags.
// The result side may stall at any time; the four-entry queue then fills and pixel.ready drops.
module box_filter_3x3_mean_core
    import bf3_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    bf3_pixel_if.sink     pixel,
    bf3_result_if.source  result,
    bf3_cfg_if.sink       cfg
);

    bf3_push_t         push;
    bf3_head_t         head;
    logic              pop;
    logic [QCNT_W-1:0] queue_count;

    bf3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel       (pixel),
        .cfg         (cfg),
        .queue_count (queue_count),
        .push        (push)
    );

    bf3_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .count (queue_count)
    );

    bf3_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

[rtl/bf3_checker.sv]
// Port-level checker of the box filter and its bind to the top level.
`include "box_filter_3x3_mean_core_defines.svh"

module bf3_checker
    import bf3_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 res_valid,
    input logic                 res_ready,
    input logic [PIX_W-1:0]     pixel_out,
    input logic [ROW_W-1:0]     out_row,
    input logic [COL_OUT_W-1:0] out_col,
    input logic                 last_of_run
);

    logic                 pend_reg;
    logic [ROW_W-1:0]     prev_row_reg;
    logic [COL_OUT_W-1:0] prev_col_reg;

    // A request that is not the last of its run is a border pixel whose interior
    // partner comes next.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            pend_reg <= !last_of_run;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            prev_row_reg <= out_row;
            prev_col_reg <= out_col;
        end
    end

    `BF3_ASSERT_NEXT(a_hold_valid, clk, rst_n, res_valid && !res_ready, res_valid)
    `BF3_ASSERT_NEXT(a_hold_data, clk, rst_n, res_valid && !res_ready, $stable(pixel_out) && $stable(out_row) && $stable(out_col) && $stable(last_of_run))
    `BF3_ASSERT_IMPLIES(a_pair_last, clk, rst_n, res_valid && pend_reg, last_of_run)
    `BF3_ASSERT_IMPLIES(a_pair_pos, clk, rst_n, res_valid && pend_reg, (out_row == prev_row_reg - 16'd1) && (out_col == prev_col_reg - 10'd1))

endmodule

bind box_filter_3x3_mean_core bf3_checker u_bf3_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .pixel_out   (result.pixel_out),
    .out_row     (result.out_row),
    .out_col     (result.out_col),
    .last_of_run (result.last_of_run)
);

[tb/tb_box_filter_3x3_mean_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the 3x3 mean filter core, checked against a state-level mirror.

module tb_box_filter_3x3_mean_core;
    import bf3_pkg::*;

    localparam int MAX_COLS       = MAX_WIDTH_DEF;
    localparam int WINDOW_AREA    = 9;
    localparam int WINDOW_SLOTS   = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_PIXELS  = 720;
    localparam int WRAP_PIXELS    = 2;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum int {
        FILL_UNIFORM,
        FILL_EXTREME,
        FILL_FLAT,
        FILL_RAMP
    } fill_mode_t;

    logic clk = 1'b0;
    logic rst_n;

    bf3_pixel_if  pixel_bus ();
    bf3_result_if result_bus ();
    bf3_cfg_if    cfg_bus ();

    box_filter_3x3_mean_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // Mirror of the filter state.
    logic [WCFG_W-1:0] width_reg;
    logic [ROW_W-1:0]  height_reg;
    logic [PIX_W-1:0]  row_above2 [MAX_COLS];
    logic [PIX_W-1:0]  row_above1 [MAX_COLS];
    bit                above2_known [MAX_COLS];
    bit                above1_known [MAX_COLS];
    logic [PIX_W-1:0]  window [WINDOW_SLOTS];
    int unsigned       row_pos;
    int unsigned       col_pos;

    bf3_res_t queued_outputs [$];

    int send_idle_pct;
    int recv_stall_pct;
    int pixels_sent;
    int outputs_seen;
    int reg_writes;
    int images_sent;
    int error_count;
    int report_count;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned clamp_width(input int unsigned value);
        if (value < 3)
            return 3;
        if (value > MAX_COLS)
            return MAX_COLS;
        return value;
    endfunction

    function automatic int unsigned cols_in_use();
        return clamp_width(width_reg);
    endfunction

    function automatic int unsigned rows_in_use();
        return (height_reg < 3) ? 3 : height_reg;
    endfunction

    // Growing the width mid-image is only allowed when every column it exposes holds pixels.
    function automatic bit growth_is_safe(input int unsigned new_w);
        if (row_pos == 0 && col_pos == 0)
            return 1'b1;
        for (int i = 0; i < new_w; i++)
        begin
            if (!above2_known[i] || !above1_known[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int unsigned pixels_to_frame_end();
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned n;
        w = cols_in_use();
        h = rows_in_use();
        r = row_pos;
        c = col_pos;
        n = 0;
        do
        begin
            n++;
            if (c + 1 >= w)
            begin
                c = 0;
                r = (r + 1 >= h) ? 0 : r + 1;
            end
            else
                c++;
        end
        while (!(r == 0 && c == 0));
        return n;
    endfunction

    task automatic mean_filter_step(input logic [PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        int unsigned sum;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        bf3_res_t run_out [$];
        bf3_res_t item;
        w = cols_in_use();
        h = rows_in_use();
        r = row_pos;
        c = col_pos;
        top = row_above2[c];
        mid = row_above1[c];
        if (r == 0 || c == 0 || r >= h - 1 || c >= w - 1)
        begin
            item.pixel_out   = px;
            item.out_row     = ROW_W'(r);
            item.out_col     = COL_OUT_W'(c);
            item.last_of_run = 1'b0;
            run_out.push_back(item);
        end
        if (r >= 2 && c >= 2 && r <= h - 1 && c <= w - 1)
        begin
            sum = top + mid + px;
            for (int i = 0; i < WINDOW_SLOTS; i++)
                sum += window[i];
            item.pixel_out   = PIX_W'(sum / WINDOW_AREA);
            item.out_row     = ROW_W'(r - 1);
            item.out_col     = COL_OUT_W'(c - 1);
            item.last_of_run = 1'b0;
            run_out.push_back(item);
        end
        if (run_out.size() > 0)
            run_out[run_out.size() - 1].last_of_run = 1'b1;
        foreach (run_out[i])
            queued_outputs.push_back(run_out[i]);

        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = top;
        window[4] = mid;
        window[5] = px;
        row_above2[c] = mid;
        row_above1[c] = px;
        above2_known[c] = above1_known[c];
        above1_known[c] = 1'b1;

        if (c + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    function automatic string res_text(input bf3_res_t res);
        return $sformatf("pixel %0d row %0d col %0d last %0b", res.pixel_out, res.out_row,
                         res.out_col, res.last_of_run);
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (report_count < MAX_REPORTS)
        begin
            report_count++;
            $display("%s", msg);
        end
    endtask

    task automatic set_idle_mode(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:
            begin
                send_idle_pct = 46;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 46;
            end
            IDLE_BOTH:
            begin
                send_idle_pct = 33;
                recv_stall_pct = 33;
            end
            default:
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pixel_bus.valid <= 1'b0;
            @(negedge clk);
        end
        pixel_bus.valid <= 1'b1;
        pixel_bus.pixel_in <= px;
        @(posedge clk);
        while (!pixel_bus.ready)
            @(posedge clk);
        mean_filter_step(px);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic send_pixels(input int unsigned count, input fill_mode_t fill);
        logic [PIX_W-1:0] flat_px;
        logic [PIX_W-1:0] px;
        flat_px = $urandom_range(0, 1) ? '1 : PIX_W'($urandom_range(0, 255));
        for (int unsigned i = 0; i < count; i++)
        begin
            case (fill)
                FILL_UNIFORM: px = PIX_W'($urandom_range(0, 255));
                FILL_EXTREME: px = $urandom_range(0, 1) ? '1 : '0;
                FILL_FLAT:    px = flat_px;
                default:      px = PIX_W'(row_pos * 37 + col_pos * 11);
            endcase
            send_pixel(px);
        end
        pixel_bus.valid <= 1'b0;
    endtask

    task automatic drain_outputs();
        while (queued_outputs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        if (idx == REG_IMAGE_WIDTH)
            width_reg = value[WCFG_W-1:0];
        else if (idx == REG_IMAGE_HEIGHT)
            height_reg = value;
        reg_writes++;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [CFG_IDX_W-1:0] spare_index();
        return CFG_IDX_W'($urandom_range(REG_IMAGE_HEIGHT + 1, (1 << CFG_IDX_W) - 1));
    endfunction

    // Smallest image from masked and clamped register values, saturated pixels.
    task automatic test_smallest_image();
        set_idle_mode(IDLE_NONE);
        write_reg(REG_IMAGE_WIDTH, 16'hF803);
        write_reg(REG_IMAGE_HEIGHT, '0);
        write_reg(spare_index(), CFG_DATA_W'($urandom_range(0, 65535)));
        for (int i = 0; i < 9; i++)
            send_pixel((i == 0) ? 8'd254 : '1);
        pixel_bus.valid <= 1'b0;
        images_sent++;
        drain_outputs();
    endtask

    // Tallest image cut short: both dimensions shrink while a row is in progress.
    task automatic test_mid_image_shrink();
        write_reg(REG_IMAGE_WIDTH, 16'd4);
        write_reg(REG_IMAGE_HEIGHT, '1);
        for (int i = 0; i < 10; i++)
            send_pixel((i % 2) ? '1 : '0);
        pixel_bus.valid <= 1'b0;
        drain_outputs();
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        send_pixel(8'd128);
        pixel_bus.valid <= 1'b0;
        images_sent++;
        drain_outputs();
    endtask

    task automatic test_random_images();
        logic [CFG_DATA_W-1:0] new_w;
        logic [CFG_DATA_W-1:0] new_h;
        int unsigned count;
        int unsigned pick;
        int start_pixels;
        int phase;
        fill_mode_t fill;
        start_pixels = pixels_sent;
        phase = 0;
        while (pixels_sent - start_pixels < RANDOM_PIXELS)
        begin
            set_idle_mode(idle_mode_t'(phase % 4));
            phase++;

            pick = $urandom_range(0, 99);
            if (pick < 70)
                new_w = CFG_DATA_W'($urandom_range(3, 16));
            else if (pick < 88)
                new_w = CFG_DATA_W'($urandom_range(17, 48));
            else if (pick < 95)
                new_w = CFG_DATA_W'($urandom_range(0, 2));
            else
                new_w = {5'($urandom_range(1, 31)), 11'($urandom_range(3, 40))};
            pick = $urandom_range(0, 99);
            if (pick < 75)
                new_h = CFG_DATA_W'($urandom_range(3, 8));
            else if (pick < 88)
                new_h = CFG_DATA_W'($urandom_range(9, 16));
            else
                new_h = CFG_DATA_W'($urandom_range(0, 2));

            if ($urandom_range(0, 99) < 85 &&
                (clamp_width(new_w[WCFG_W-1:0]) <= cols_in_use() ||
                 growth_is_safe(clamp_width(new_w[WCFG_W-1:0]))))
                write_reg(REG_IMAGE_WIDTH, new_w);
            if ($urandom_range(0, 99) < 85)
                write_reg(REG_IMAGE_HEIGHT, new_h);
            if ($urandom_range(0, 99) < 10)
                write_reg(spare_index(), CFG_DATA_W'($urandom_range(0, 65535)));

            count = pixels_to_frame_end();
            if ($urandom_range(0, 99) < 20)
                count = $urandom_range(1, count);
            else
                images_sent++;

            pick = $urandom_range(0, 99);
            if (pick < 60)
                fill = FILL_UNIFORM;
            else if (pick < 75)
                fill = FILL_EXTREME;
            else if (pick < 90)
                fill = FILL_FLAT;
            else
                fill = FILL_RAMP;

            send_pixels(count, fill);
            drain_outputs();
        end
        if (!(row_pos == 0 && col_pos == 0))
        begin
            send_pixels(pixels_to_frame_end(), FILL_UNIFORM);
            images_sent++;
            drain_outputs();
        end
    endtask

    // Widest row: every column of the row stores in use, then the wrap into the next row.
    task automatic test_widest_image();
        set_idle_mode(IDLE_BOTH);
        write_reg(REG_IMAGE_WIDTH, '1);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        send_pixels(cols_in_use() + WRAP_PIXELS, FILL_UNIFORM);
        drain_outputs();
    endtask

    always @(negedge clk)
        result_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge clk)
    begin : output_check
        bf3_res_t got;
        bf3_res_t want;
        if (result_bus.valid && result_bus.ready)
        begin
            outputs_seen++;
            got.pixel_out   = result_bus.pixel_out;
            got.out_row     = result_bus.out_row;
            got.out_col     = result_bus.out_col;
            got.last_of_run = result_bus.last_of_run;
            if (queued_outputs.size() == 0)
                note_failure($sformatf("Unexpected output: pixel %0d row %0d col %0d last %0b",
                                       got.pixel_out, got.out_row, got.out_col,
                                       got.last_of_run));
            else
            begin
                want = queued_outputs.pop_front();
                if (got.pixel_out !== want.pixel_out || got.out_row !== want.out_row ||
                    got.out_col !== want.out_col || got.last_of_run !== want.last_of_run)
                    note_failure($sformatf("Output %0d mismatch: expected %s, got %s",
                                           outputs_seen, res_text(want), res_text(got)));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_bus.valid && pixel_bus.ready) || (result_bus.valid && result_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        pixel_bus.valid = 1'b0;
        pixel_bus.pixel_in = '0;
        result_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_IMAGE_WIDTH;
        cfg_bus.data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pixels_sent = 0;
        outputs_seen = 0;
        reg_writes = 0;
        images_sent = 0;
        error_count = 0;
        report_count = 0;
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        foreach (row_above2[i])
        begin
            row_above2[i] = '0;
            row_above1[i] = '0;
            above2_known[i] = 1'b0;
            above1_known[i] = 1'b0;
        end
        foreach (window[i])
            window[i] = '0;
        row_pos = 0;
        col_pos = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_smallest_image();
        test_mid_image_shrink();
        test_random_images();
        test_widest_image();
        drain_outputs();

        if (queued_outputs.size() != 0)
            note_failure($sformatf("%0d outputs never arrived", queued_outputs.size()));

        $display("Sent %0d pixels in %0d images with %0d register writes, under four idle modes.",
                 pixels_sent, images_sent, reg_writes);
        $display("Checked %0d filter outputs; %0d failures.", outputs_seen, error_count);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/bf3_pkg.sv
rtl/bf3_if.sv
rtl/bf3_front.sv
rtl/bf3_queue.sv
rtl/bf3_back.sv
rtl/box_filter_3x3_mean_core.sv
rtl/bf3_checker.sv
tb/tb_box_filter_3x3_mean_core.sv
